[rtl/core/i2ew_pkg.sv]
// Package for the integer-to-English word token core.
// Holds widths, word codes, slot layout, the digit record type and FSM enums.
// No dependencies.
package i2ew_pkg;

  localparam int unsigned VALUE_W         = 31;
  localparam int unsigned WORD_W          = 5;
  localparam int unsigned NUM_DIGITS      = 10;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned BCD_W           = NUM_DIGITS * DIGIT_W;
  localparam int unsigned CNT_W           = $clog2(VALUE_W);
  localparam int unsigned NUM_GROUPS      = 4;
  localparam int unsigned SLOTS_PER_GROUP = 5;
  // Four groups of five word slots, plus one slot for the word Zero.
  localparam int unsigned NUM_SLOTS       = NUM_GROUPS * SLOTS_PER_GROUP + 1;
  localparam int unsigned SLOT_W          = $clog2(NUM_SLOTS);
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  // Word codes.
  localparam logic [WORD_W-1:0] CODE_ZERO     = 5'd0;
  localparam logic [WORD_W-1:0] CODE_TEN      = 5'd10;
  localparam logic [WORD_W-1:0] CODE_TWENTY   = 5'd20;
  localparam logic [WORD_W-1:0] CODE_HUNDRED  = 5'd28;
  localparam logic [WORD_W-1:0] CODE_THOUSAND = 5'd29;
  localparam logic [WORD_W-1:0] CODE_MILLION  = 5'd30;
  localparam logic [WORD_W-1:0] CODE_BILLION  = 5'd31;

  // Group indexes, most significant group first.
  localparam logic [1:0] GRP_BILLION  = 2'd0;
  localparam logic [1:0] GRP_MILLION  = 2'd1;
  localparam logic [1:0] GRP_THOUSAND = 2'd2;
  localparam logic [1:0] GRP_UNIT     = 2'd3;

  // Slot kinds inside a group.
  localparam logic [2:0] KIND_HUND_DIGIT = 3'd0;
  localparam logic [2:0] KIND_HUNDRED    = 3'd1;
  localparam logic [2:0] KIND_TENS       = 3'd2;
  localparam logic [2:0] KIND_ONES       = 3'd3;
  localparam logic [2:0] KIND_SCALE      = 3'd4;
  localparam logic [2:0] KIND_ZERO       = 3'd5;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit_arr_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] h;
    logic [DIGIT_W-1:0] t;
    logic [DIGIT_W-1:0] o;
  } grp_digits_t;

  // One classified number as it travels from the front to the back.
  typedef struct packed {
    digit_arr_t           digits;
    logic [NUM_SLOTS-1:0] mask;
  } num_rec_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } front_state_e;

  typedef enum logic {
    BE_IDLE,
    BE_EMIT
  } back_state_e;

  // Hundreds, tens and ones digits of one group. The billion group has only
  // a ones digit.
  function automatic grp_digits_t group_digits(input digit_arr_t d, input logic [1:0] g);
    grp_digits_t r;
    r = '0;
    case (g)
      GRP_BILLION: begin
        r.o = d[9];
      end
      GRP_MILLION: begin
        r.h = d[8];
        r.t = d[7];
        r.o = d[6];
      end
      GRP_THOUSAND: begin
        r.h = d[5];
        r.t = d[4];
        r.o = d[3];
      end
      default: begin
        r.h = d[2];
        r.t = d[1];
        r.o = d[0];
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/core/i2ew_front.sv]
// Front end: accepts a number, converts it to ten decimal digits by
// shift-and-add-3, and builds the mask of word slots that will be spoken.
// Depends on i2ew_pkg.
module i2ew_front import i2ew_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [VALUE_W-1:0]   value_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output num_rec_t             rec_o
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

  front_state_e       state_q, state_d;
  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // Slots that carry a word for the given digits; the last slot marks zero.
  function automatic logic [NUM_SLOTS-1:0] slot_mask(input digit_arr_t d);
    logic [NUM_SLOTS-1:0] m;
    grp_digits_t          gd;
    logic                 h_nz;
    logic                 r_nz;
    m = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      gd   = group_digits(d, 2'(g));
      h_nz = (gd.h != '0);
      r_nz = (gd.t != '0) || (gd.o != '0);
      m[g*SLOTS_PER_GROUP + 0] = h_nz;
      m[g*SLOTS_PER_GROUP + 1] = h_nz;
      m[g*SLOTS_PER_GROUP + 2] = r_nz;
      m[g*SLOTS_PER_GROUP + 3] = (gd.t >= 4'd2) && (gd.o != '0);
      m[g*SLOTS_PER_GROUP + 4] = (h_nz || r_nz) && (g != NUM_GROUPS - 1);
    end
    m[NUM_SLOTS-1] = (m[NUM_SLOTS-2:0] == '0);
    return m;
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i*DIGIT_W +: DIGIT_W] = (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) ?
                                      bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3 :
                                      bcd_q[i*DIGIT_W +: DIGIT_W];
    end
  end

  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    case (state_q)
      FE_IDLE: begin
        if (in_valid_i) begin
          bin_d   = value_i;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = FE_CONV;
        end
      end
      FE_CONV: begin
        bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
        bin_d = {bin_q[VALUE_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (!q_full_i) begin
          push_o  = 1'b1;
          state_d = FE_IDLE;
        end
      end
      default: begin
        state_d = FE_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != FE_IDLE);
  assign rec_o.digits = bcd_q;
  assign rec_o.mask   = slot_mask(bcd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  // The conversion always runs exactly one step per input bit.
  a_conv_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FE_CONV && cnt_q == CNT_LAST) |=> (state_q == FE_PUSH))
    else $error("front conversion did not end after the last bit");

endmodule

[rtl/core/i2ew_queue.sv]
// Short queue of classified numbers between the front and the back end.
// Depends on i2ew_pkg.
module i2ew_queue import i2ew_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  num_rec_t push_rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output num_rec_t pop_rec_o,
  output logic     empty_o
);

  num_rec_t          entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o    = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_rec_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_rec_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

[rtl/core/i2ew_back.sv]
// Back end: walks the word slots of one number and emits one word code per
// transaction through a registered output stage. Depends on i2ew_pkg.
module i2ew_back import i2ew_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  num_rec_t          q_rec_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] word_code_o,
  output logic              last_word_o
);

  back_state_e          state_q, state_d;
  digit_arr_t           digits_q, digits_d;
  logic [NUM_SLOTS-1:0] mask_q, mask_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic                 out_valid_q, out_valid_d;
  logic [WORD_W-1:0]    word_q, word_d;
  logic                 last_q, last_d;

  logic                 out_free;
  logic                 cur_hit;
  logic                 rest_any;
  logic [1:0]           grp;
  logic [2:0]           kind;
  grp_digits_t          gd;
  logic [WORD_W-1:0]    code;

  assign out_free = !out_valid_q || !out_stall_i;
  assign cur_hit  = mask_q[slot_q];
  assign rest_any = |((mask_q >> slot_q) >> 1);

  // Split the slot index into group and kind.
  always_comb begin
    if (slot_q < SLOT_W'(SLOTS_PER_GROUP)) begin
      grp  = GRP_BILLION;
      kind = 3'(slot_q);
    end else if (slot_q < SLOT_W'(2 * SLOTS_PER_GROUP)) begin
      grp  = GRP_MILLION;
      kind = 3'(slot_q - SLOT_W'(SLOTS_PER_GROUP));
    end else if (slot_q < SLOT_W'(3 * SLOTS_PER_GROUP)) begin
      grp  = GRP_THOUSAND;
      kind = 3'(slot_q - SLOT_W'(2 * SLOTS_PER_GROUP));
    end else begin
      grp  = GRP_UNIT;
      kind = 3'(slot_q - SLOT_W'(3 * SLOTS_PER_GROUP));
    end
  end

  assign gd = group_digits(digits_q, grp);

  always_comb begin
    case (kind)
      KIND_HUND_DIGIT: code = WORD_W'(gd.h);
      KIND_HUNDRED:    code = CODE_HUNDRED;
      KIND_TENS: begin
        if (gd.t >= 4'd2) begin
          code = CODE_TWENTY + WORD_W'(gd.t - 4'd2);
        end else if (gd.t == 4'd1) begin
          code = CODE_TEN + WORD_W'(gd.o);
        end else begin
          code = WORD_W'(gd.o);
        end
      end
      KIND_ONES:  code = WORD_W'(gd.o);
      KIND_SCALE: code = CODE_BILLION - WORD_W'(grp);
      default:    code = CODE_ZERO;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    digits_d    = digits_q;
    mask_d      = mask_q;
    slot_d      = slot_q;
    word_d      = word_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;
    case (state_q)
      BE_IDLE: begin
        if (!q_empty_i) begin
          pop_o    = 1'b1;
          digits_d = q_rec_i.digits;
          mask_d   = q_rec_i.mask;
          slot_d   = '0;
          state_d  = BE_EMIT;
        end
      end
      BE_EMIT: begin
        if (!cur_hit || out_free) begin
          if (cur_hit) begin
            out_valid_d = 1'b1;
            word_d      = code;
            last_d      = !rest_any;
          end
          if (rest_any) begin
            slot_d = slot_q + 1'b1;
          end else begin
            state_d = BE_IDLE;
          end
        end
      end
      default: begin
        state_d = BE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BE_IDLE;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    mask_q   <= mask_d;
    word_q   <= word_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign word_code_o = word_q;
  assign last_word_o = last_q;

  // While a number is being spoken, a word slot at or above the pointer is
  // still pending.
  a_pending_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BE_EMIT) |-> ((mask_q >> slot_q) != '0))
    else $error("back end walking a number with no words left");

endmodule

[rtl/core/integer_to_english_word_tokens_core.sv]
// Top level of the integer-to-English word token core.
// Connects front end, queue and back end; depends on i2ew_pkg and those modules.
//
//   Channel   Signals                                  Direction  Handshake
//   input     in_valid_i, in_stall_o, value_i           in         valid / stall
//   output    out_valid_o, out_stall_i, word_code_o,    out        valid / stall
//             last_word_o
//
// The front end takes one number at a time: it accepts the number, runs a
// bit-serial binary-to-decimal conversion (one input bit per cycle), then hands
// the digits to the queue. The back end walks at most 21 slots per number, so
// while the output does not stall, the conversion loop sets the sustained rate.
// Reset clears all control state; the block accepts a transaction right after it.
// A stalled output holds its word, the back end waits, the two-entry queue fills,
// and the front end then holds its finished number and stalls its input.
module integer_to_english_word_tokens_core import i2ew_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [WORD_W-1:0]  word_code_o,
  output logic               last_word_o
);

  // Classified numbers pass from the front end to the back end through this
  // queue, so a slow consumer does not stop a conversion in progress.
  num_rec_t push_rec;
  num_rec_t pop_rec;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  i2ew_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  i2ew_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_rec_o  (pop_rec),
    .empty_o    (q_empty)
  );

  // The back end emits words in order and flags the final one of each number.
  i2ew_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_rec_i     (pop_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_code_o (word_code_o),
    .last_word_o (last_word_o)
  );

endmodule
